// ----- sv/i2cms_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the I2C master sequencer.
// No dependencies; imported by i2cms_shift and i2c_master_sequencer_core.
package i2cms_pkg;

	localparam int BYTE_W = 8;
	localparam int ADDR_W = 7;
	localparam int CMD_W  = 3;

	localparam logic [CMD_W-1:0] CMD_START_WR = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START_RD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STOP     = 3'd4;

	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic REG_LSB_FIRST      = 1'b1;

	// Control of the shared bit shifter
	typedef struct packed {
		logic load;
		logic shift;
	} shift_ctrl_t;

	function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[BYTE_W-1-i] = v[i];
		end
		return r;
	endfunction

endpackage

// ----- sv/i2c_master_sequencer_core.sv -----
`timescale 1ns / 1ps
// Top level of the I2C master sequencer: command decode, interval sequencer, result register.
// Depends on i2cms_pkg and i2cms_shift.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   in       | in_valid / in_stall  | command, data_byte, address_byte, master_ack,
//            |                      | slave_data, slave_ack_level
//   out      | out_valid / out_stall| scl_level, sda_level, sample_point, last,
//            |                      | read_byte, ack_received, address_nacked, rejected
//   cfg      | cfg_we               | cfg_index, cfg_data
//
// Each command is accepted, then yields one half-bit interval per cycle while out_stall
// is low: a start gives 20 or 22, a write or read byte 18, a stop 2, a rejected command 1;
// an unused code is accepted and yields none. The sequencer and the shared byte shifter
// handle one command at a time; in_stall is high until its last interval sits in the result
// register. arst_n clears the sequencer, the open-transaction flag, the configuration and the
// result valid.
module i2c_master_sequencer_core
	import i2cms_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [BYTE_W-1:0] address_byte,
	input  logic              master_ack,
	input  logic [BYTE_W-1:0] slave_data,
	input  logic              slave_ack_level,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              scl_level,
	output logic              sda_level,
	output logic              sample_point,
	output logic              last,
	output logic [BYTE_W-1:0] read_byte,
	output logic              ack_received,
	output logic              address_nacked,
	output logic              rejected,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_BITS  = 3'd2;
	localparam logic [2:0] ST_SACK  = 3'd3;
	localparam logic [2:0] ST_RBITS = 3'd4;
	localparam logic [2:0] ST_MACK  = 3'd5;
	localparam logic [2:0] ST_STOP  = 3'd6;
	localparam logic [2:0] ST_REJ   = 3'd7;

	logic [2:0]        state_q;
	logic              half_q;
	logic [2:0]        bit_q;
	logic              open_q;
	logic              nack_q;
	logic              is_start_q;
	logic              mack_q;
	logic              sack_q;
	logic [BYTE_W-1:0] rbyte_q;
	logic [ADDR_W-1:0] dev_addr_q;
	logic              lsb_first_q;

	logic              out_valid_q;
	logic              scl_q, sda_q, smp_q, last_q, ack_q, nack_out_q, rej_q;
	logic [BYTE_W-1:0] rbyte_out_q;

	logic              in_acc;
	logic              emit;
	logic [BYTE_W-1:0] addr_byte;
	logic [BYTE_W-1:0] tx_byte;
	logic              wire_bit;
	shift_ctrl_t       sh_ctrl;

	// Interval produced this cycle
	logic [2:0]        state_d;
	logic              scl_d, sda_d, smp_d, last_d, ack_d, nack_d, rej_d, open_d;
	logic [BYTE_W-1:0] rbyte_d;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign emit     = (state_q != ST_IDLE) && (!out_valid_q || !out_stall);

	assign addr_byte = (address_byte != '0) ? address_byte : {dev_addr_q, command[0]};
	assign tx_byte   = (command == CMD_WRITE) ? data_byte : addr_byte;

	assign sh_ctrl.load  = in_acc;
	assign sh_ctrl.shift = emit && (state_q == ST_BITS) && half_q;

	i2cms_shift u_shift (
		.clk       (clk),
		.ctrl      (sh_ctrl),
		.load_byte (lsb_first_q ? reverse8(tx_byte) : tx_byte),
		.wire_bit  (wire_bit)
	);

	always_comb begin
		state_d = state_q;
		scl_d   = half_q;
		sda_d   = 1'b1;
		smp_d   = 1'b0;
		last_d  = 1'b0;
		ack_d   = 1'b0;
		nack_d  = 1'b0;
		rej_d   = 1'b0;
		rbyte_d = '0;
		open_d  = open_q;
		unique case (state_q)
			ST_IDLE: begin
				scl_d = 1'b0;
			end
			ST_START: begin
				scl_d = 1'b1;
				sda_d = !half_q;
				if (half_q) begin
					state_d = ST_BITS;
				end
			end
			ST_BITS: begin
				sda_d = wire_bit;
				if (half_q && bit_q == 3'd7) begin
					state_d = ST_SACK;
				end
			end
			ST_SACK: begin
				smp_d = half_q;
				if (half_q) begin
					if (is_start_q && sack_q) begin
						// address refused: append a stop
						open_d  = 1'b0;
						state_d = ST_STOP;
					end else begin
						if (is_start_q) begin
							open_d = 1'b1;
						end
						ack_d   = !sack_q;
						last_d  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_RBITS: begin
				scl_d = !half_q;
				smp_d = !half_q;
				if (half_q && bit_q == 3'd7) begin
					state_d = ST_MACK;
				end
			end
			ST_MACK: begin
				sda_d = !mack_q;
				if (half_q) begin
					last_d  = 1'b1;
					rbyte_d = rbyte_q;
					state_d = ST_IDLE;
				end
			end
			ST_STOP: begin
				sda_d = 1'b0;
				if (half_q) begin
					last_d  = 1'b1;
					nack_d  = nack_q;
					open_d  = 1'b0;
					state_d = ST_IDLE;
				end
			end
			ST_REJ: begin
				scl_d   = 1'b1;
				last_d  = 1'b1;
				rej_d   = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			half_q      <= 1'b0;
			bit_q       <= '0;
			open_q      <= 1'b0;
			nack_q      <= 1'b0;
			dev_addr_q  <= '0;
			lsb_first_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DEVICE_ADDRESS: dev_addr_q <= cfg_data;
					REG_LSB_FIRST:      lsb_first_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_acc) begin
				half_q <= 1'b0;
				bit_q  <= '0;
				case (command)
					CMD_START_WR, CMD_START_RD: begin
						state_q <= ST_START;
						nack_q  <= slave_ack_level;
					end
					CMD_WRITE: state_q <= open_q ? ST_BITS : ST_REJ;
					CMD_READ:  state_q <= open_q ? ST_RBITS : ST_REJ;
					CMD_STOP: begin
						state_q <= ST_STOP;
						nack_q  <= 1'b0;
					end
					default: state_q <= ST_IDLE;
				endcase
			end else if (emit) begin
				state_q <= state_d;
				open_q  <= open_d;
				half_q  <= (state_d == state_q) ? !half_q : 1'b0;
				if (half_q && (state_q == ST_BITS || state_q == ST_RBITS)) begin
					bit_q <= bit_q + 3'd1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command payload and result register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			is_start_q <= (command == CMD_START_WR) || (command == CMD_START_RD);
			mack_q     <= master_ack;
			sack_q     <= slave_ack_level;
			rbyte_q    <= lsb_first_q ? reverse8(slave_data) : slave_data;
		end
		if (emit) begin
			scl_q       <= scl_d;
			sda_q       <= sda_d;
			smp_q       <= smp_d;
			last_q      <= last_d;
			rbyte_out_q <= rbyte_d;
			ack_q       <= ack_d;
			nack_out_q  <= nack_d;
			rej_q       <= rej_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign scl_level      = scl_q;
	assign sda_level      = sda_q;
	assign sample_point   = smp_q;
	assign last           = last_q;
	assign read_byte      = rbyte_out_q;
	assign ack_received   = ack_q;
	assign address_nacked = nack_out_q;
	assign rejected       = rej_q;

`ifndef NO_ASSERTIONS
	a_sample_scl_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_point |-> scl_level)
		else $error("SDA sampled with SCL low");

	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> last && scl_level && sda_level)
		else $error("rejected result is not a lone idle interval");

	a_nack_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && address_nacked |-> last && !ack_received && !open_q)
		else $error("address NACK without closing stop");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a command's intervals");
`endif

endmodule

// ----- sv/i2cms_shift.sv -----
`timescale 1ns / 1ps
// Byte shifter that presents the next wire bit, most significant first.
// Depends on i2cms_pkg for shift_ctrl_t and BYTE_W.
module i2cms_shift
	import i2cms_pkg::*;
(
	input  logic              clk,
	input  shift_ctrl_t       ctrl,
	input  logic [BYTE_W-1:0] load_byte,
	output logic              wire_bit
);

	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= load_byte;
		end else if (ctrl.shift) begin
			byte_q <= {byte_q[BYTE_W-2:0], 1'b0};
		end
	end

	assign wire_bit = byte_q[BYTE_W-1];

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for i2c_master_sequencer_core: random and directed commands against a predictor.
// Depends on i2cms_pkg and the sequencer RTL; needs no other files.
module testbench;
	import i2cms_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 40;
	localparam int PHASE_ITEMS = 72;

	// codes the block must ignore
	localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] abyte;
		logic              mack;
		logic [BYTE_W-1:0] sdat;
		logic              sack;
	} bus_cmd_t;

	typedef struct packed {
		logic              scl;
		logic              sda;
		logic              smp;
		logic              fin;
		logic [BYTE_W-1:0] rbyte;
		logic              ack;
		logic              anack;
		logic              rej;
	} interval_t;

	class i2c_wire_scoreboard;
		interval_t         pending[$];
		logic [ADDR_W-1:0] dev_addr;
		logic              lsb_order;
		logic              txn_open;
		int                errors;
		int                checked;
		int                commands;
		int                rejects;
		int                addr_nacks;
		int                settings;

		function new();
			dev_addr  = '0;
			lsb_order = 1'b0;
			txn_open  = 1'b0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void set_reg(logic idx, logic [ADDR_W-1:0] v);
			if (idx == REG_DEVICE_ADDRESS) begin
				dev_addr = v;
			end else begin
				lsb_order = v[0];
			end
			settings++;
		endfunction

		function logic [BYTE_W-1:0] flip(logic [BYTE_W-1:0] v);
			return {<<{v}};
		endfunction

		function void add(logic scl, logic sda, logic smp);
			interval_t t;
			t = '0;
			t.scl = scl;
			t.sda = sda;
			t.smp = smp;
			pending.push_back(t);
		endfunction

		// the eight bits in wire order, then the slave acknowledge slot
		function void put_byte(logic [BYTE_W-1:0] v);
			logic [BYTE_W-1:0] wire_bits;
			wire_bits = lsb_order ? flip(v) : v;
			for (int i = BYTE_W - 1; i >= 0; i--) begin
				add(1'b0, wire_bits[i], 1'b0);
				add(1'b1, wire_bits[i], 1'b0);
			end
			add(1'b0, 1'b1, 1'b0);
			add(1'b1, 1'b1, 1'b1);
		endfunction

		function void note_command(bus_cmd_t c);
			logic [BYTE_W-1:0] addr;
			int                tail;
			case (c.cmd)
				CMD_START_WR, CMD_START_RD: begin
					addr = (c.abyte != 0) ? c.abyte : {dev_addr, c.cmd == CMD_START_RD};
					add(1'b1, 1'b1, 1'b0);
					add(1'b1, 1'b0, 1'b0);
					put_byte(addr);
					if (!c.sack) begin
						txn_open = 1'b1;
						pending[pending.size() - 1].ack = 1'b1;
					end else begin
						// address refused: close the bus with a stop
						add(1'b0, 1'b0, 1'b0);
						add(1'b1, 1'b0, 1'b0);
						txn_open = 1'b0;
						pending[pending.size() - 1].anack = 1'b1;
						addr_nacks++;
					end
				end
				CMD_WRITE, CMD_READ: begin
					if (!txn_open) begin
						add(1'b1, 1'b1, 1'b0);
						pending[pending.size() - 1].rej = 1'b1;
						rejects++;
					end else if (c.cmd == CMD_WRITE) begin
						put_byte(c.data);
						pending[pending.size() - 1].ack = !c.sack;
					end else begin
						for (int i = 0; i < BYTE_W; i++) begin
							add(1'b1, 1'b1, 1'b1);
							add(1'b0, 1'b1, 1'b0);
						end
						add(1'b0, !c.mack, 1'b0);
						add(1'b1, !c.mack, 1'b0);
						pending[pending.size() - 1].rbyte = lsb_order ? flip(c.sdat) : c.sdat;
					end
				end
				CMD_STOP: begin
					add(1'b0, 1'b0, 1'b0);
					add(1'b1, 1'b0, 1'b0);
					txn_open = 1'b0;
				end
				default: begin
					// ignored codes produce nothing
				end
			endcase
			if (c.cmd <= CMD_STOP) begin
				tail = pending.size() - 1;
				pending[tail].fin = 1'b1;
				commands++;
			end
		endfunction

		task cmp(string field, int got, int want);
			if (got != want) begin
				report($sformatf("interval %0d %s got %0h want %0h", checked, field, got, want));
			end
		endtask

		task check_interval(interval_t got);
			interval_t want;
			if (pending.size() == 0) begin
				report($sformatf("interval %0d arrived with nothing expected", checked));
			end else begin
				want = pending.pop_front();
				cmp("scl_level", got.scl, want.scl);
				cmp("sda_level", got.sda, want.sda);
				cmp("sample_point", got.smp, want.smp);
				cmp("last", got.fin, want.fin);
				cmp("read_byte", got.rbyte, want.rbyte);
				cmp("ack_received", got.ack, want.ack);
				cmp("address_nacked", got.anack, want.anack);
				cmp("rejected", got.rej, want.rej);
			end
			checked++;
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] data_byte;
	logic [BYTE_W-1:0] address_byte;
	logic              master_ack;
	logic [BYTE_W-1:0] slave_data;
	logic              slave_ack_level;
	logic              out_valid;
	logic              out_stall;
	logic              scl_level;
	logic              sda_level;
	logic              sample_point;
	logic              last;
	logic [BYTE_W-1:0] read_byte;
	logic              ack_received;
	logic              address_nacked;
	logic              rejected;
	logic              cfg_we;
	logic              cfg_index;
	logic [ADDR_W-1:0] cfg_data;

	i2c_wire_scoreboard sb = new();
	bit                 calm;
	bit                 hold_req;
	int                 idle_cycles;

	i2c_master_sequencer_core i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.data_byte       (data_byte),
		.address_byte    (address_byte),
		.master_ack      (master_ack),
		.slave_data      (slave_data),
		.slave_ack_level (slave_ack_level),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.scl_level       (scl_level),
		.sda_level       (sda_level),
		.sample_point    (sample_point),
		.last            (last),
		.read_byte       (read_byte),
		.ack_received    (ack_received),
		.address_nacked  (address_nacked),
		.rejected        (rejected),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// both sides of the block, seen at the clock edge
	always @(posedge clk) begin
		bus_cmd_t  c;
		interval_t r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				r = '{scl_level, sda_level, sample_point, last, read_byte,
					ack_received, address_nacked, rejected};
				sb.check_interval(r);
			end
			if (in_valid && !in_stall) begin
				c = '{command, data_byte, address_byte, master_ack, slave_data,
					slave_ack_level};
				sb.note_command(c);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stall before each interval, one long hold-off on request
	initial begin : receiver
		int n;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				n = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				n = calm ? 0 : $urandom_range(0, 11);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// returns right after the accepting edge; the next call moves to the falling edge
	task automatic issue(input logic [CMD_W-1:0] k, input logic [BYTE_W-1:0] d,
			input logic [BYTE_W-1:0] a, input logic m, input logic [BYTE_W-1:0] s,
			input logic sk);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command         <= k;
		data_byte       <= d;
		address_byte    <= a;
		master_ack      <= m;
		slave_data      <= s;
		slave_ack_level <= sk;
		in_valid        <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		// an ignored code is accepted without producing any interval
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [ADDR_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic random_phase(input int target);
		int               done;
		int               n;
		logic [CMD_W-1:0] k;
		done = 0;
		while (done < target) begin
			if ($urandom_range(0, 99) < 15) begin
				k = CMD_W'($urandom_range(0, 7));
				issue(k, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
					1'($urandom));
				if (k <= CMD_STOP) done++;
			end else begin
				k = $urandom_range(0, 1) ? CMD_START_RD : CMD_START_WR;
				issue(k, 8'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00,
					1'($urandom), 8'($urandom), $urandom_range(0, 9) == 0);
				n = $urandom_range(1, 5);
				repeat (n) begin
					k = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
					issue(k, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
						$urandom_range(0, 4) == 0);
				end
				done += n + 1;
				if ($urandom_range(0, 4) != 0) begin
					issue(CMD_STOP, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
						1'($urandom));
					done++;
				end
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		command         = CMD_STOP;
		data_byte       = '0;
		address_byte    = '0;
		master_ack      = 1'b0;
		slave_data      = '0;
		slave_ack_level = 1'b0;
		out_stall       = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = REG_DEVICE_ADDRESS;
		cfg_data        = '0;
		calm            = 1'b0;
		hold_req        = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_DEVICE_ADDRESS, 7'h55);
		write_reg(REG_LSB_FIRST, 7'd0);
		// data and stop with no open transaction
		issue(CMD_WRITE, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b0);
		issue(CMD_READ,  8'h00, 8'h00, 1'b1, 8'hFF, 1'b0);
		issue(CMD_STOP,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
		issue(CMD_START_WR, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
		issue(CMD_WRITE, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0);
		// data NACK keeps the transaction open
		issue(CMD_WRITE, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b1);
		issue(CMD_READ,  8'h00, 8'h00, 1'b1, 8'hA5, 1'b0);
		issue(CMD_READ,  8'h00, 8'h00, 1'b1, 8'h00, 1'b1);
		issue(CMD_READ,  8'hFF, 8'h00, 1'b0, 8'hFF, 1'b0);
		// repeated start with a raw address byte
		issue(CMD_START_RD, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0);
		issue(CMD_READ,  8'h00, 8'h00, 1'b0, 8'h3C, 1'b0);
		issue(CMD_STOP,  8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1);
		// address refused, then data is rejected
		issue(CMD_START_WR, 8'h00, 8'h01, 1'b0, 8'h00, 1'b1);
		issue(CMD_WRITE, 8'h5A, 8'h00, 1'b0, 8'h00, 1'b0);
		issue(CMD_RSVD_A, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1);
		issue(CMD_RSVD_B, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
		issue(CMD_RSVD_C, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b0);
		issue(CMD_START_RD, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
		issue(CMD_READ,  8'h00, 8'h00, 1'b0, 8'h80, 1'b0);
		issue(CMD_STOP,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
		drain();

		write_reg(REG_DEVICE_ADDRESS, 7'h7F);
		write_reg(REG_LSB_FIRST, 7'd1);
		issue(CMD_START_WR, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
		issue(CMD_WRITE, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0);
		issue(CMD_READ,  8'h00, 8'h00, 1'b1, 8'h01, 1'b0);
		issue(CMD_STOP,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0);
		drain();

		write_reg(REG_DEVICE_ADDRESS, 7'h00);
		write_reg(REG_LSB_FIRST, 7'd0);
		random_phase(PHASE_ITEMS / 2);
		drain();
		random_phase(PHASE_ITEMS / 2);
		drain();

		// long receiver hold-off while commands keep coming
		write_reg(REG_DEVICE_ADDRESS, 7'h7F);
		write_reg(REG_LSB_FIRST, 7'd1);
		hold_req = 1'b1;
		random_phase(PHASE_ITEMS);
		drain();

		write_reg(REG_DEVICE_ADDRESS, 7'($urandom));
		write_reg(REG_LSB_FIRST, 7'($urandom_range(0, 1)));
		calm = 1'b1;
		random_phase(PHASE_ITEMS);
		drain();
		calm = 1'b0;

		write_reg(REG_DEVICE_ADDRESS, 7'($urandom));
		write_reg(REG_LSB_FIRST, 7'($urandom_range(0, 1)));
		random_phase(PHASE_ITEMS);
		drain();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.pending.size() != 0) begin
			sb.report($sformatf("%0d intervals never arrived", sb.pending.size()));
		end
		$display("ran %0d commands (%0d rejected, %0d address NACKs) over %0d register writes",
			sb.commands, sb.rejects, sb.addr_nacks, sb.settings);
		$display("checked %0d bus intervals, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
